FILE: hw/rtl/tlru_pkg.sv
`default_nettype none

package tlru_pkg;

  // Command codes of the input item; code 3 has no meaning and acts as a query
  typedef enum logic [1:0] {
    CMD_TOUCH = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_RESET = 2'd2
  } cmd_e;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_e;

  localparam int SET_IDX_W = 6;
  localparam int WAY_IDX_W = 3;
  localparam int VICTIM_W  = 3;

endpackage

`default_nettype wire

FILE: hw/rtl/tlru_ram.sv
`default_nettype none

module tlru_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tlru_update.sv
`default_nettype none

module tlru_update #(
  parameter int WAYS = 8,
  localparam int AGE_W = $clog2(WAYS),
  localparam int ENTRY_W = WAYS * AGE_W
) (
  input  wire tlru_pkg::cmd_e                   cmd_i,
  input  wire logic [tlru_pkg::WAY_IDX_W-1:0]   way_index_i,
  input  wire logic [ENTRY_W-1:0]               entry_i,
  output logic      [ENTRY_W-1:0]               entry_o,
  output logic      [tlru_pkg::VICTIM_W-1:0]    victim_o
);

  logic             way_ok;
  logic [AGE_W-1:0] old_age;
  logic [AGE_W-1:0] age;

  assign way_ok = {{(32-tlru_pkg::WAY_IDX_W){1'b0}}, way_index_i} < 32'(WAYS);

  // Pick the touched way's current age
  always_comb begin
    old_age = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (32'(w) == {{(32-tlru_pkg::WAY_IDX_W){1'b0}}, way_index_i}) begin
        old_age = entry_i[w*AGE_W +: AGE_W];
      end
    end
  end

  // Touch: ways younger than the touched one age, it goes to 0; reset: age = way
  always_comb begin
    entry_o = entry_i;
    age     = '0;
    unique case (cmd_i)
      tlru_pkg::CMD_TOUCH: begin
        if (way_ok) begin
          for (int w = 0; w < WAYS; w++) begin
            age = entry_i[w*AGE_W +: AGE_W];
            if (32'(w) == {{(32-tlru_pkg::WAY_IDX_W){1'b0}}, way_index_i}) begin
              entry_o[w*AGE_W +: AGE_W] = '0;
            end else if (age < old_age) begin
              entry_o[w*AGE_W +: AGE_W] = age + AGE_W'(1);
            end
          end
        end
      end
      tlru_pkg::CMD_RESET: begin
        for (int w = 0; w < WAYS; w++) begin
          entry_o[w*AGE_W +: AGE_W] = AGE_W'(w);
        end
      end
      default: begin
        entry_o = entry_i;
      end
    endcase
  end

  // Ages form a permutation, so the victim is the lowest way holding the top age
  always_comb begin
    victim_o = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (entry_o[w*AGE_W +: AGE_W] == AGE_W'(WAYS - 1)) begin
        victim_o = tlru_pkg::VICTIM_W'(w);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/true_lru_age_replacement_core.sv
`default_nettype none
// Structure: an accepted item's RAM entry is read and updated in one stage, then the
//   result is held in the output register until it leaves.
// Throughput: one item per cycle while out_stall_i is low, including back-to-back
//   touches of one set; set by the single read-modify-write pass through the age RAM.
// Reset: after rst_ni releases, a clearing pass writes the initial ages into all
//   NUM_SETS entries, one per cycle; in_stall_o stays high until the pass ends.

module true_lru_age_replacement_core #(
  parameter int NUM_SETS = 64,
  parameter int WAYS     = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Input channel
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [1:0]                       cmd_i,
  input  wire logic [tlru_pkg::SET_IDX_W-1:0]   set_index_i,
  input  wire logic [tlru_pkg::WAY_IDX_W-1:0]   way_index_i,
  // Result channel
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [tlru_pkg::VICTIM_W-1:0]    victim_way_o
);

  localparam int AGE_W   = $clog2(WAYS);
  localparam int ENTRY_W = WAYS * AGE_W;
  localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

  // Controller and clearing pass
  tlru_pkg::state_e state_q, state_d;
  logic [SET_W-1:0] clr_cnt_q, clr_cnt_d;

  // Read stage: item whose RAM entry arrives this cycle
  logic                            s1_valid_q, s1_valid_d;
  tlru_pkg::cmd_e                  s1_cmd_q;
  logic [tlru_pkg::WAY_IDX_W-1:0]  s1_way_q;
  logic [SET_W-1:0]                s1_addr_q;
  logic                            s1_hit_q;
  logic                            s1_fwd_q;

  // Last entry written by an item, for forwarding
  logic [ENTRY_W-1:0]              last_wr_q;

  // Output register
  logic                            out_valid_q, out_valid_d;
  logic [tlru_pkg::VICTIM_W-1:0]   victim_q;

  logic                            accept;
  logic                            advance;
  logic                            in_hit;
  logic [SET_W-1:0]                in_addr;
  tlru_pkg::cmd_e                  in_cmd;

  logic                            ram_we;
  logic [SET_W-1:0]                ram_waddr;
  logic [ENTRY_W-1:0]              ram_wdata;
  logic [ENTRY_W-1:0]              ram_rdata;
  logic                            item_we;

  logic [ENTRY_W-1:0]              init_entry;
  logic [ENTRY_W-1:0]              cur_entry;
  logic [ENTRY_W-1:0]              new_entry;
  logic [tlru_pkg::VICTIM_W-1:0]   new_victim;

  // Initial pattern: each way's age equals its way number
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      init_entry[w*AGE_W +: AGE_W] = AGE_W'(w);
    end
  end

  // Input side decode; sets beyond the table yield victim 0 and touch nothing
  assign in_hit  = {{(32-tlru_pkg::SET_IDX_W){1'b0}}, set_index_i} < 32'(NUM_SETS);
  assign in_addr = SET_W'(set_index_i);
  assign in_cmd  = tlru_pkg::cmd_e'(cmd_i);

  // The read stage moves on whenever the output register is free or drains
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != tlru_pkg::ST_RUN) || (s1_valid_q && !advance);
  assign accept     = in_valid_i && !in_stall_o;

  // Write back the updated entry as the item leaves the read stage
  assign item_we = s1_valid_q && advance && s1_hit_q;

  always_comb begin
    if (state_q == tlru_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = init_entry;
    end else begin
      ram_we    = item_we;
      ram_waddr = s1_addr_q;
      ram_wdata = new_entry;
    end
  end

  tlru_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SETS)
  ) u_age_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // A read that met a write to the same set returned stale data: use the forwarded copy
  assign cur_entry = s1_fwd_q ? last_wr_q : ram_rdata;

  tlru_update #(
    .WAYS (WAYS)
  ) u_update (
    .cmd_i       (s1_cmd_q),
    .way_index_i (s1_way_q),
    .entry_i     (cur_entry),
    .entry_o     (new_entry),
    .victim_o    (new_victim)
  );

  // Clearing pass sequencing
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      tlru_pkg::ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + SET_W'(1);
        if (clr_cnt_q == SET_W'(NUM_SETS - 1)) begin
          state_d = tlru_pkg::ST_RUN;
        end
      end
      tlru_pkg::ST_RUN: begin
        state_d = tlru_pkg::ST_RUN;
      end
      default: begin
        state_d = tlru_pkg::ST_CLEAR;
      end
    endcase
  end

  // Pipeline valids: load on accept, drop once the item moves to the output
  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    if (s1_valid_q && advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlru_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q  <= in_cmd;
      s1_way_q  <= way_index_i;
      s1_addr_q <= in_addr;
      s1_hit_q  <= in_hit;
      s1_fwd_q  <= item_we && (s1_addr_q == in_addr);
    end
    if (item_we) begin
      last_wr_q <= new_entry;
    end
    if (s1_valid_q && advance) begin
      victim_q <= s1_hit_q ? new_victim : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign victim_way_o = victim_q;

endmodule

`default_nettype wire
